// ===== hw/rtl/ole_pkg.sv =====
package ole_pkg;

    // Fixed field widths of the item and result words.
    localparam int MODE_BITS   = 3;
    localparam int VALUE_BITS  = 32;
    localparam int POS_BITS    = 5;
    localparam int STATUS_BITS = 3;
    localparam int DATA_BITS   = 32;

    // Default sizes handed to the top level.
    localparam int DEF_DEPTH     = 16;
    localparam int DEF_WORD_BITS = 32;

    // Operation carried by an item word.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_BACK  = 3'd1,
        MODE_INS_POS   = 3'd2,
        MODE_DEL_FRONT = 3'd3,
        MODE_DEL_BACK  = 3'd4,
        MODE_DEL_POS   = 3'd5,
        MODE_SEARCH    = 3'd6,
        MODE_READOUT   = 3'd7
    } mode_t;

    // Outcome reported with a result word.
    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_POS   = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    // What one cell loads at the next clock edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_FROM_FRONT
    } cell_op_t;

    // Movement applied to the cell chain.
    typedef enum logic [1:0] {
        CHAIN_NONE,
        CHAIN_INSERT,
        CHAIN_DELETE,
        CHAIN_ROTATE
    } chain_op_t;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_READOUT
    } state_t;

endpackage

// ===== hw/rtl/ole_in_if.sv =====
interface ole_in_if;
    logic                              valid;
    logic                              ready;
    logic [ole_pkg::MODE_BITS-1:0]     mode;
    logic signed [ole_pkg::VALUE_BITS-1:0] value;
    logic [ole_pkg::POS_BITS-1:0]      position;

    modport source (output valid, mode, value, position, input ready);
    modport sink   (input valid, mode, value, position, output ready);
endinterface

// ===== hw/rtl/ole_out_if.sv =====
interface ole_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [ole_pkg::STATUS_BITS-1:0]      status;
    logic [ole_pkg::POS_BITS-1:0]         found_position;
    logic signed [ole_pkg::DATA_BITS-1:0] data;
    logic                                 last;

    modport source (output valid, status, found_position, data, last, input ready);
    modport sink   (input valid, status, found_position, data, last, output ready);
endinterface

// ===== hw/rtl/ole_cell.sv =====
module ole_cell #(
    parameter int WORD_BITS = ole_pkg::DEF_WORD_BITS
) (
    input  logic                 clk,
    input  ole_pkg::cell_op_t    op,
    input  logic [WORD_BITS-1:0] load_word,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [WORD_BITS-1:0] right_word,
    input  logic [WORD_BITS-1:0] front_word,
    input  logic [WORD_BITS-1:0] key,
    output logic [WORD_BITS-1:0] word,
    output logic                 match
);
    import ole_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    // Pick the source of the stored word for this cycle.
    always_comb
    begin
        case (op)
            CELL_LOAD:       word_next = load_word;
            CELL_FROM_LEFT:  word_next = left_word;
            CELL_FROM_RIGHT: word_next = right_word;
            CELL_FROM_FRONT: word_next = front_word;
            default:         word_next = word_reg;
        endcase
    end

    // The entry itself carries no reset; occupancy is tracked by the controller.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = (word_reg == key);

endmodule

// ===== hw/rtl/ordered_list_engine.sv =====
// Channel   Role    Fields                                 Moves
// item      sink    mode, value, position                  one request word
// result    source  status, found_position, data, last     one response word
//
// In every mode except read-out the cell chain shifts, loads or compares in
// parallel and the response word goes into the output register.
// Read-out of N entries sends N words, one per cycle unless the result stalls,
// as the chain rotates front to back; the next request is taken after the last.
// Reset clears the entry count and the controller; entry words are not reset.
// A stalled result holds the output register, and the chain waits with it.
module ordered_list_engine #(
    parameter int DEPTH     = ole_pkg::DEF_DEPTH,
    parameter int WORD_BITS = ole_pkg::DEF_WORD_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    ole_in_if.sink    item,
    ole_out_if.source result
);
    import ole_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     rd_left_reg, rd_left_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [POS_BITS-1:0]  out_found_reg, out_found_next;
    logic [DATA_BITS-1:0] out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    logic                 slot_free;
    logic                 accept;
    mode_t                mode;
    logic [WORD_BITS-1:0] key;

    logic [WORD_BITS-1:0] cell_word [DEPTH];
    logic [DEPTH-1:0]     cell_match;
    cell_op_t             cell_op   [DEPTH];

    chain_op_t            chain_op;
    logic [IDX_W-1:0]     chain_idx;
    logic [IDX_W-1:0]     wrap_idx;
    logic [IDX_W-1:0]     del_idx;
    logic [WORD_BITS-1:0] del_word;
    logic [DATA_BITS-1:0] del_data;
    logic [DATA_BITS-1:0] front_data;
    logic                 hit_any;
    logic [IDX_W-1:0]     hit_idx;

    logic [CMP_W-1:0]     pos_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic                 ins_pos_ok;
    logic                 del_pos_ok;
    logic                 is_full;
    logic                 is_empty;

    // Handshake on the request side.
    assign slot_free  = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == S_IDLE) && slot_free;
    assign accept     = item.valid && item.ready;
    assign mode       = mode_t'(item.mode);

    // Word conversion between the port widths and the stored width.
    generate
        if (WORD_BITS <= VALUE_BITS) begin : g_key_cut
            assign key = item.value[WORD_BITS-1:0];
        end else begin : g_key_ext
            assign key = {{(WORD_BITS - VALUE_BITS){1'b0}}, item.value};
        end
        if (WORD_BITS >= DATA_BITS) begin : g_data_cut
            assign del_data   = del_word[DATA_BITS-1:0];
            assign front_data = cell_word[0][DATA_BITS-1:0];
        end else begin : g_data_ext
            assign del_data   = {{(DATA_BITS - WORD_BITS){del_word[WORD_BITS-1]}}, del_word};
            assign front_data = {{(DATA_BITS - WORD_BITS){cell_word[0][WORD_BITS-1]}},
                                 cell_word[0]};
        end
    endgenerate

    // Range checks on the requested position.
    assign pos_ext    = CMP_W'(item.position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign ins_pos_ok = (pos_ext >= CMP_W'(1)) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign del_pos_ok = (pos_ext >= CMP_W'(1)) && (pos_ext <= cnt_ext);
    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign wrap_idx   = IDX_W'(count_reg - CNT_W'(1));

    // Index of the entry removed by a delete.
    always_comb
    begin
        case (mode)
            MODE_DEL_FRONT: del_idx = '0;
            MODE_DEL_BACK:  del_idx = wrap_idx;
            default:        del_idx = IDX_W'(pos_ext - CMP_W'(1));
        endcase
    end
    assign del_word = cell_word[del_idx];

    // First matching occupied cell, front first.
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (cell_match[i] && (CNT_W'(i) < count_reg)) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (mode == MODE_READOUT) && (count_reg > CNT_W'(1)))
                    state_next = S_READOUT;
            end
            S_READOUT:
            begin
                if (slot_free && (rd_left_reg == CNT_W'(1)))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Chain movement, list size and the response word.
    always_comb
    begin
        chain_op        = CHAIN_NONE;
        chain_idx       = '0;
        count_next      = count_reg;
        rd_left_next    = rd_left_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_found_next  = '0;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    case (mode)
                        MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS:
                        begin
                            if (is_full) begin
                                out_status_next = STAT_FULL;
                            end else if ((mode == MODE_INS_POS) && !ins_pos_ok) begin
                                out_status_next = STAT_BAD_POS;
                            end else begin
                                chain_op   = CHAIN_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                if (mode == MODE_INS_BACK)
                                    chain_idx = IDX_W'(count_reg);
                                else if (mode == MODE_INS_POS)
                                    chain_idx = IDX_W'(pos_ext - CMP_W'(1));
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS:
                        begin
                            if (is_empty) begin
                                out_status_next = STAT_EMPTY;
                            end else if ((mode == MODE_DEL_POS) && !del_pos_ok) begin
                                out_status_next = STAT_BAD_POS;
                            end else begin
                                chain_op      = CHAIN_DELETE;
                                chain_idx     = del_idx;
                                count_next    = count_reg - CNT_W'(1);
                                out_data_next = del_data;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            if (is_empty)
                                out_status_next = STAT_EMPTY;
                            else if (hit_any)
                                out_found_next = POS_BITS'(CNT_W'(hit_idx) + CNT_W'(1));
                            else
                                out_status_next = STAT_NOT_FOUND;
                        end
                        default:
                        begin
                            // Read-out: the front word leaves as the chain rotates.
                            if (is_empty) begin
                                out_status_next = STAT_EMPTY;
                            end else begin
                                chain_op      = CHAIN_ROTATE;
                                out_data_next = front_data;
                                out_last_next = (count_reg == CNT_W'(1));
                                rd_left_next  = count_reg - CNT_W'(1);
                            end
                        end
                    endcase
                end
            end
            S_READOUT:
            begin
                if (slot_free) begin
                    chain_op        = CHAIN_ROTATE;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_found_next  = '0;
                    out_data_next   = front_data;
                    out_last_next   = (rd_left_reg == CNT_W'(1));
                    rd_left_next    = rd_left_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Per-cell command derived from the chain movement.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_op[i] = CELL_HOLD;
            case (chain_op)
                CHAIN_INSERT:
                begin
                    if (IDX_W'(i) == chain_idx)
                        cell_op[i] = CELL_LOAD;
                    else if (IDX_W'(i) > chain_idx)
                        cell_op[i] = CELL_FROM_LEFT;
                end
                CHAIN_DELETE:
                begin
                    if (IDX_W'(i) >= chain_idx)
                        cell_op[i] = CELL_FROM_RIGHT;
                end
                CHAIN_ROTATE:
                begin
                    if (IDX_W'(i) == wrap_idx)
                        cell_op[i] = CELL_FROM_FRONT;
                    else if (IDX_W'(i) < wrap_idx)
                        cell_op[i] = CELL_FROM_RIGHT;
                end
                default: cell_op[i] = CELL_HOLD;
            endcase
        end
    end

    // The row of cells, each inner one linked to its two neighbors.
    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [WORD_BITS-1:0] left_word;
            logic [WORD_BITS-1:0] right_word;
            if (g == 0) begin : g_first
                assign left_word = key;
            end else begin : g_left
                assign left_word = cell_word[g-1];
            end
            if (g == DEPTH - 1) begin : g_end
                assign right_word = cell_word[g];
            end else begin : g_right
                assign right_word = cell_word[g+1];
            end
            ole_cell #(
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .clk        (clk),
                .op         (cell_op[g]),
                .load_word  (key),
                .left_word  (left_word),
                .right_word (right_word),
                .front_word (cell_word[0]),
                .key        (key),
                .word       (cell_word[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = STATUS_BITS'(out_status_reg);
    assign result.found_position = out_found_reg;
    assign result.data           = out_data_reg;
    assign result.last           = out_last_reg;

    // The list never holds more than DEPTH entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // Words left to read are pending exactly while in read-out.
    a_readout_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READOUT) == (rd_left_reg != '0))
        else $error("read-out counter out of step with state");

    // The list size changes only when a request word is taken.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

    // A failing outcome is always the single, final word of its request.
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STAT_OK)) |-> out_last_reg)
        else $error("error status without last");

endmodule
